// ===== rtl/core/aet_pkg.sv =====
// Package for the adjacency edge table: constants, operation codes and word types.
package aet_pkg;

  localparam int NodeCountDefault  = 1024;
  localparam int MaxDegreeDefault  = 16;
  localparam int SpareSlotsDefault = 2;
  localparam int NodeW = 10;
  localparam int LenW  = 31;
  localparam int EdgeW = 14;
  localparam logic [EdgeW-1:0] EdgeLimit = 14'd16383;
  localparam int QueueDepth = 2;

  typedef enum logic [2:0] {
    FUNC_CLEAR  = 3'd0,
    FUNC_LOAD   = 3'd1,
    FUNC_QUERY  = 3'd2,
    FUNC_ADD    = 3'd3,
    FUNC_DELETE = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_PRESENT = 2'd1,
    STAT_NO_ROOM = 2'd2
  } stat_t;

  typedef struct packed {
    logic [2:0]       func;
    logic [NodeW-1:0] node_a;
    logic [NodeW-1:0] node_b;
    logic [LenW-1:0]  edge_length;
  } in_word_t;

  typedef struct packed {
    logic             found;
    logic [1:0]       status;
    logic [EdgeW-1:0] edge_total;
  } out_word_t;

  // Classified command handed from the front part to the back part.
  typedef struct packed {
    func_t            op;
    logic             in_range;
    logic             self_loop;
    logic [NodeW-1:0] node_a;
    logic [NodeW-1:0] node_b;
    logic [LenW-1:0]  edge_length;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLEAR, ST_RD_DEG, ST_SCAN, ST_SCAN_WAIT, ST_DECIDE,
    ST_RM_FIND, ST_RM_WAIT, ST_RM_LAST, ST_RM_WRITE, ST_APPEND, ST_DONE
  } back_state_t;

endpackage

// ===== rtl/core/adjacency_edge_table.sv =====
// Top level of the adjacency edge table: front classifier, command queue and slot engine.
//
//  Channel   Direction  Handshake                        Word
//  command   in         start high while busy low        in_word  (aet_pkg::in_word_t)
//  result    out        done high for one cycle          result   (aet_pkg::out_word_t)
//
// One command is worked on at a time. Every in-range command but a clear
// scans node_a's row in the slot memory, which has one registered read port;
// a delete of a present edge then finds and refills the holes in both rows,
// and a load or add with room makes the two appends. A clear writes one
// degree entry per cycle. After reset the same clearing pass runs with busy
// low but commands queued behind it. The receiver cannot stall: each result
// is on the result port for exactly the one cycle in which done is high.
module adjacency_edge_table #(
  parameter int NODE_COUNT  = aet_pkg::NodeCountDefault,
  parameter int MAX_DEGREE  = aet_pkg::MaxDegreeDefault,
  parameter int SPARE_SLOTS = aet_pkg::SpareSlotsDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  aet_pkg::in_word_t  in_word,
  output logic               busy,
  output logic               done,
  output aet_pkg::out_word_t result
);

  logic          cmd_valid;
  logic          cmd_take;
  logic          idle_back;
  aet_pkg::cmd_t cmd;

  // The front part classifies each command word and queues it.
  aet_front #(
    .NODE_COUNT(NODE_COUNT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .in_word   (in_word),
    .busy      (busy),
    .idle_back (idle_back),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  // The back part owns the slot memories, degree tables and edge count.
  aet_back #(
    .NODE_COUNT  (NODE_COUNT),
    .MAX_DEGREE  (MAX_DEGREE),
    .SPARE_SLOTS (SPARE_SLOTS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .idle_back (idle_back),
    .done      (done),
    .result    (result)
  );

endmodule

// ===== rtl/core/aet_front.sv =====
// Front part: takes commands, classifies them and queues them for the back part.
module aet_front #(
  parameter int NODE_COUNT = aet_pkg::NodeCountDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  aet_pkg::in_word_t in_word,
  output logic              busy,
  input  logic              idle_back,
  output logic              cmd_valid,
  output aet_pkg::cmd_t     cmd,
  input  logic              cmd_take
);

  localparam int PtrW = $clog2(aet_pkg::QueueDepth);

  aet_pkg::cmd_t   queue [aet_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [PtrW:0]   fill;
  logic            pending;
  aet_pkg::cmd_t   cmd_in;
  logic            accept;

  // One command is in flight at a time: each operation reads what the last one left.
  assign busy   = pending;
  assign accept = start && !pending;

  always_comb begin
    cmd_in.node_a      = in_word.node_a;
    cmd_in.node_b      = in_word.node_b;
    cmd_in.edge_length = in_word.edge_length;
    cmd_in.in_range    = (32'(in_word.node_a) < NODE_COUNT) &&
                         (32'(in_word.node_b) < NODE_COUNT);
    cmd_in.self_loop   = in_word.node_a == in_word.node_b;
    case (in_word.func)
      aet_pkg::FUNC_CLEAR:  cmd_in.op = aet_pkg::FUNC_CLEAR;
      aet_pkg::FUNC_LOAD:   cmd_in.op = aet_pkg::FUNC_LOAD;
      aet_pkg::FUNC_ADD:    cmd_in.op = aet_pkg::FUNC_ADD;
      aet_pkg::FUNC_DELETE: cmd_in.op = aet_pkg::FUNC_DELETE;
      default:              cmd_in.op = aet_pkg::FUNC_QUERY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      queue[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      fill    <= '0;
      pending <= 1'b0;
    end else begin
      if (accept) begin
        wr_ptr  <= wr_ptr + 1'b1;
        pending <= 1'b1;
      end else if (idle_back && fill == '0) begin
        pending <= 1'b0;
      end
      if (cmd_take) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fill <= fill + PtrW'(0) + (PtrW+1)'(accept) - (PtrW+1)'(cmd_take);
    end
  end

  assign cmd_valid = fill != '0;
  assign cmd       = queue[rd_ptr];

endmodule

// ===== rtl/core/aet_back.sv =====
// Back part: walks the slot memories and degree tables to carry out one command.
module aet_back #(
  parameter int NODE_COUNT  = aet_pkg::NodeCountDefault,
  parameter int MAX_DEGREE  = aet_pkg::MaxDegreeDefault,
  parameter int SPARE_SLOTS = aet_pkg::SpareSlotsDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  input  aet_pkg::cmd_t      cmd,
  output logic               cmd_take,
  output logic               idle_back,
  output logic               done,
  output aet_pkg::out_word_t result
);

  localparam int NodeIdxW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int SlotW    = $clog2(MAX_DEGREE);
  localparam int DegW     = $clog2(MAX_DEGREE + 1);
  localparam int AddrW    = NodeIdxW + SlotW;
  localparam int SlotCnt  = NODE_COUNT * (2 ** SlotW);
  localparam int ClrW     = NodeIdxW + 1;

  // Slot memories: one write and one registered read per cycle.
  logic [aet_pkg::NodeW-1:0] nbr_mem [SlotCnt];
  logic [aet_pkg::LenW-1:0]  len_mem [SlotCnt];
  logic [AddrW-1:0]          rd_addr;
  logic [AddrW-1:0]          wr_addr;
  logic                      wr_en;
  logic [aet_pkg::NodeW-1:0] wr_nbr;
  logic [aet_pkg::LenW-1:0]  wr_len;
  logic [aet_pkg::NodeW-1:0] rd_nbr;
  logic [aet_pkg::LenW-1:0]  rd_len;

  // Degree tables: one read and one write per cycle.
  logic [DegW-1:0]     deg_mem  [NODE_COUNT];
  logic [DegW-1:0]     ldeg_mem [NODE_COUNT];
  logic [NodeIdxW-1:0] deg_raddr;
  logic [DegW-1:0]     deg_rd;
  logic [DegW-1:0]     ldeg_rd;
  logic                deg_we;
  logic                ldeg_we;
  logic [NodeIdxW-1:0] deg_waddr;
  logic [DegW-1:0]     deg_wd;
  logic [DegW-1:0]     ldeg_wd;

  aet_pkg::back_state_t state;
  aet_pkg::back_state_t state_next;
  aet_pkg::cmd_t        cur;
  logic [aet_pkg::EdgeW-1:0] edge_count;
  logic [ClrW-1:0]      clr_idx;
  logic                 boot;       // clearing pass after reset, which reports nothing
  logic                 side;       // 0 works on node_a, 1 on node_b
  logic                 rd_phase;   // degree read step: 0 node_a, 1 node_b
  logic [DegW-1:0]      deg_a;
  logic [DegW-1:0]      deg_b;
  logic [DegW-1:0]      ldeg_a;
  logic [DegW-1:0]      ldeg_b;
  logic [DegW-1:0]      scan_i;
  logic                 found;
  logic [1:0]           status;
  logic [SlotW-1:0]     hole;
  logic [DegW-1:0]      app_cnt;

  logic [NodeIdxW-1:0] na;
  logic [NodeIdxW-1:0] nb;
  logic [NodeIdxW-1:0] side_node;
  logic [aet_pkg::NodeW-1:0] other_node;
  logic [DegW-1:0]     side_deg;
  logic [DegW:0]       cap_a;
  logic [DegW:0]       cap_b;
  logic [DegW:0]       lim_a;
  logic [DegW:0]       lim_b;
  logic                has_room;
  logic                do_insert;
  logic                scan_hit;

  assign na         = cur.node_a[NodeIdxW-1:0];
  assign nb         = cur.node_b[NodeIdxW-1:0];
  assign side_node  = side ? nb : na;
  assign other_node = side ? cur.node_a : cur.node_b;
  assign side_deg   = side ? deg_b : deg_a;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      nbr_mem[wr_addr] <= wr_nbr;
      len_mem[wr_addr] <= wr_len;
    end
    rd_nbr <= nbr_mem[rd_addr];
    rd_len <= len_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (deg_we) begin
      deg_mem[deg_waddr] <= deg_wd;
    end
    if (ldeg_we) begin
      ldeg_mem[deg_waddr] <= ldeg_wd;
    end
    deg_rd  <= deg_mem[deg_raddr];
    ldeg_rd <= ldeg_mem[deg_raddr];
  end

  // Capacity is the loaded degree plus the spare slots, capped at the row size.
  always_comb begin
    cap_a = (DegW+1)'(ldeg_a) + (DegW+1)'(SPARE_SLOTS);
    cap_b = (DegW+1)'(ldeg_b) + (DegW+1)'(SPARE_SLOTS);
    if (cap_a > (DegW+1)'(MAX_DEGREE)) cap_a = (DegW+1)'(MAX_DEGREE);
    if (cap_b > (DegW+1)'(MAX_DEGREE)) cap_b = (DegW+1)'(MAX_DEGREE);
    if (cur.op == aet_pkg::FUNC_LOAD) begin
      lim_a = (DegW+1)'(MAX_DEGREE);
      lim_b = (DegW+1)'(MAX_DEGREE);
    end else begin
      lim_a = cap_a;
      lim_b = cap_b;
    end
    if (cur.self_loop) begin
      has_room = (DegW+1)'(deg_a) + (DegW+1)'(2) <= lim_a;
    end else begin
      has_room = ((DegW+1)'(deg_a) < lim_a) && ((DegW+1)'(deg_b) < lim_b);
    end
    do_insert = cur.in_range && has_room &&
                (cur.op == aet_pkg::FUNC_LOAD ||
                 (cur.op == aet_pkg::FUNC_ADD && !found));
  end

  assign scan_hit = rd_nbr == other_node;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      aet_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          if (cmd.op == aet_pkg::FUNC_CLEAR) state_next = aet_pkg::ST_CLEAR;
          else                               state_next = aet_pkg::ST_RD_DEG;
        end
      end
      aet_pkg::ST_CLEAR: begin
        if (clr_idx == ClrW'(NODE_COUNT - 1)) state_next = aet_pkg::ST_DONE;
      end
      aet_pkg::ST_RD_DEG: begin
        if (rd_phase) begin
          if (!cur.in_range) state_next = aet_pkg::ST_DECIDE;
          else               state_next = aet_pkg::ST_SCAN;
        end
      end
      aet_pkg::ST_SCAN: begin
        if (scan_i >= deg_a) state_next = aet_pkg::ST_DECIDE;
        else                 state_next = aet_pkg::ST_SCAN_WAIT;
      end
      aet_pkg::ST_SCAN_WAIT: begin
        if (scan_hit) state_next = aet_pkg::ST_DECIDE;
        else          state_next = aet_pkg::ST_SCAN;
      end
      aet_pkg::ST_DECIDE: begin
        if (cur.op == aet_pkg::FUNC_DELETE && found) state_next = aet_pkg::ST_RM_FIND;
        else if (do_insert)                          state_next = aet_pkg::ST_APPEND;
        else                                         state_next = aet_pkg::ST_DONE;
      end
      aet_pkg::ST_RM_FIND: begin
        state_next = aet_pkg::ST_RM_WAIT;
      end
      aet_pkg::ST_RM_WAIT: begin
        if (scan_hit) state_next = aet_pkg::ST_RM_LAST;
        else          state_next = aet_pkg::ST_RM_FIND;
      end
      aet_pkg::ST_RM_LAST: begin
        state_next = aet_pkg::ST_RM_WRITE;
      end
      aet_pkg::ST_RM_WRITE: begin
        if (side) state_next = aet_pkg::ST_DONE;
        else      state_next = aet_pkg::ST_RM_FIND;
      end
      aet_pkg::ST_APPEND: begin
        if (app_cnt == DegW'(1)) state_next = aet_pkg::ST_DONE;
      end
      aet_pkg::ST_DONE: begin
        state_next = aet_pkg::ST_IDLE;
      end
      default: state_next = aet_pkg::ST_IDLE;
    endcase
  end

  // Memory and handshake controls.
  always_comb begin
    cmd_take  = 1'b0;
    idle_back = 1'b0;
    rd_addr   = {side_node, scan_i[SlotW-1:0]};
    wr_en     = 1'b0;
    wr_addr   = {side_node, side_deg[SlotW-1:0]};
    wr_nbr    = other_node;
    wr_len    = cur.edge_length;
    deg_raddr = nb;
    deg_we    = 1'b0;
    ldeg_we   = 1'b0;
    deg_waddr = side_node;
    deg_wd    = side_deg;
    ldeg_wd   = side ? ldeg_b : ldeg_a;
    case (state)
      aet_pkg::ST_IDLE: begin
        idle_back = 1'b1;
        cmd_take  = cmd_valid;
        deg_raddr = cmd.node_a[NodeIdxW-1:0];
      end
      aet_pkg::ST_CLEAR: begin
        deg_we    = 1'b1;
        ldeg_we   = 1'b1;
        deg_waddr = clr_idx[NodeIdxW-1:0];
        deg_wd    = '0;
        ldeg_wd   = '0;
      end
      aet_pkg::ST_SCAN: begin
        rd_addr = {na, scan_i[SlotW-1:0]};
      end
      aet_pkg::ST_RM_FIND: begin
        rd_addr = {side_node, scan_i[SlotW-1:0]};
      end
      aet_pkg::ST_RM_LAST: begin
        rd_addr = {side_node, SlotW'(side_deg - DegW'(1))};
      end
      aet_pkg::ST_RM_WRITE: begin
        wr_en     = 1'b1;
        wr_addr   = {side_node, hole};
        wr_nbr    = rd_nbr;
        wr_len    = rd_len;
        deg_we    = 1'b1;
        deg_wd    = side_deg - DegW'(1);
      end
      aet_pkg::ST_APPEND: begin
        wr_en   = 1'b1;
        deg_we  = 1'b1;
        deg_wd  = side_deg + DegW'(1);
        ldeg_we = cur.op == aet_pkg::FUNC_LOAD;
        if (cur.op == aet_pkg::FUNC_LOAD &&
            (side ? ldeg_b : ldeg_a) < DegW'(MAX_DEGREE)) begin
          ldeg_wd = (side ? ldeg_b : ldeg_a) + DegW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= aet_pkg::ST_CLEAR;
      edge_count <= '0;
      clr_idx    <= '0;
      boot       <= 1'b1;
      done       <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      case (state)
        aet_pkg::ST_IDLE: begin
          clr_idx <= '0;
          if (cmd_valid && cmd.op == aet_pkg::FUNC_CLEAR) edge_count <= '0;
        end
        aet_pkg::ST_CLEAR: clr_idx <= clr_idx + 1'b1;
        aet_pkg::ST_DECIDE: begin
          if (do_insert && edge_count < aet_pkg::EdgeLimit) edge_count <= edge_count + 1'b1;
          if (cur.op == aet_pkg::FUNC_DELETE && found && edge_count != '0) begin
            edge_count <= edge_count - 1'b1;
          end
        end
        aet_pkg::ST_DONE: begin
          done <= !boot;
          boot <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Per-command working registers.
  always_ff @(posedge clk) begin
    case (state)
      aet_pkg::ST_IDLE: begin
        cur      <= cmd;
        rd_phase <= 1'b0;
        side     <= 1'b0;
        scan_i   <= '0;
        found    <= 1'b0;
        status   <= aet_pkg::STAT_OK;
      end
      aet_pkg::ST_RD_DEG: begin
        rd_phase <= 1'b1;
        if (!rd_phase) begin
          deg_a  <= deg_rd;
          ldeg_a <= ldeg_rd;
        end else begin
          deg_b  <= deg_rd;
          ldeg_b <= ldeg_rd;
        end
      end
      aet_pkg::ST_SCAN: ;
      aet_pkg::ST_SCAN_WAIT: begin
        if (scan_hit) found <= 1'b1;
        scan_i <= scan_i + 1'b1;
      end
      aet_pkg::ST_DECIDE: begin
        scan_i  <= '0;
        app_cnt <= DegW'(2);
        if (cur.op == aet_pkg::FUNC_LOAD || cur.op == aet_pkg::FUNC_ADD) begin
          if (!cur.in_range)                          status <= aet_pkg::STAT_NO_ROOM;
          else if (cur.op == aet_pkg::FUNC_ADD && found) status <= aet_pkg::STAT_PRESENT;
          else if (!has_room)                         status <= aet_pkg::STAT_NO_ROOM;
        end
      end
      aet_pkg::ST_RM_WAIT: begin
        if (scan_hit) hole <= scan_i[SlotW-1:0];
        else          scan_i <= scan_i + 1'b1;
      end
      aet_pkg::ST_RM_WRITE: begin
        // A self loop clears its second entry on the same row in the second
        // pass; both ends of any other edge are handled one after the other.
        scan_i <= '0;
        side   <= 1'b1;
        if (side) begin
          deg_b <= deg_b - DegW'(1);
        end else begin
          deg_a <= deg_a - DegW'(1);
          if (cur.self_loop) deg_b <= deg_a - DegW'(1);
        end
      end
      aet_pkg::ST_APPEND: begin
        app_cnt <= app_cnt - DegW'(1);
        side    <= 1'b1;
        if (cur.self_loop) begin
          deg_a <= deg_a + DegW'(1);
          deg_b <= deg_a + DegW'(1);
          if (cur.op == aet_pkg::FUNC_LOAD && ldeg_a < DegW'(MAX_DEGREE)) begin
            ldeg_a <= ldeg_a + DegW'(1);
            ldeg_b <= ldeg_a + DegW'(1);
          end
        end else begin
          if (!side) deg_a <= deg_a + DegW'(1);
          else       deg_b <= deg_b + DegW'(1);
          if (cur.op == aet_pkg::FUNC_LOAD) begin
            if (!side && ldeg_a < DegW'(MAX_DEGREE)) ldeg_a <= ldeg_a + DegW'(1);
            if (side && ldeg_b < DegW'(MAX_DEGREE))  ldeg_b <= ldeg_b + DegW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  assign result.found      = found;
  assign result.status     = status;
  assign result.edge_total = edge_count;

endmodule

// ===== test/adjacency_edge_table_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the adjacency edge table with a built-in graph predictor.
module adjacency_edge_table_tb;

  localparam int Nodes    = aet_pkg::NodeCountDefault;
  localparam int MaxDeg   = aet_pkg::MaxDegreeDefault;
  localparam int Spare    = aet_pkg::SpareSlotsDefault;
  localparam int CycleCap = 4000000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  aet_pkg::in_word_t  in_word = '0;
  logic               busy;
  logic               done;
  aet_pkg::out_word_t result;

  adjacency_edge_table uut (
    .clk(clk), .rst(rst), .start(start), .in_word(in_word),
    .busy(busy), .done(done), .result(result)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow copy of the graph. Only slots below a node's degree are ever read.
  logic [aet_pkg::NodeW-1:0] nbr_row [Nodes][MaxDeg];
  logic [aet_pkg::LenW-1:0]  len_row [Nodes][MaxDeg];
  int unsigned      deg [Nodes];
  int unsigned      loaded [Nodes];
  int unsigned      edges;

  aet_pkg::in_word_t  pending_words[$];
  aet_pkg::out_word_t expected_results[$];
  int        mismatches = 0;
  int        cycle = 0;
  logic      quiet_driver = 1'b0;

  function automatic bit has_neighbor(int unsigned a, int unsigned b);
    for (int i = 0; i < deg[a]; i++)
      if (nbr_row[a][i] == b[aet_pkg::NodeW-1:0]) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void attach(int unsigned n, int unsigned other,
                                 logic [aet_pkg::LenW-1:0] len);
    if (deg[n] >= MaxDeg) return;
    nbr_row[n][deg[n]] = other[aet_pkg::NodeW-1:0];
    len_row[n][deg[n]] = len;
    deg[n]++;
  endfunction

  function automatic void detach(int unsigned n, int unsigned other);
    for (int i = 0; i < deg[n]; i++) begin
      if (nbr_row[n][i] == other[aet_pkg::NodeW-1:0]) begin
        deg[n]--;
        nbr_row[n][i] = nbr_row[n][deg[n]];
        len_row[n][i] = len_row[n][deg[n]];
        return;
      end
    end
  endfunction

  function automatic int unsigned cap_of(int unsigned n);
    int unsigned c;
    c = loaded[n] + Spare;
    return (c > MaxDeg) ? MaxDeg : c;
  endfunction

  function automatic bit has_room(int unsigned a, int unsigned b, bit capped);
    int unsigned la, lb;
    la = capped ? cap_of(a) : MaxDeg;
    lb = capped ? cap_of(b) : MaxDeg;
    if (a == b) return deg[a] + 2 <= la;
    return deg[a] < la && deg[b] < lb;
  endfunction

  function automatic void link_edge(int unsigned a, int unsigned b,
                                    logic [aet_pkg::LenW-1:0] len);
    attach(a, b, len);
    attach(b, a, len);
    if (edges < aet_pkg::EdgeLimit) edges++;
  endfunction

  // Applies one command to the shadow graph and returns the word the block should report.
  function automatic aet_pkg::out_word_t apply_command(aet_pkg::in_word_t w);
    aet_pkg::out_word_t r;
    int unsigned a, b;
    bit          in_range, hit;
    a = w.node_a;
    b = w.node_b;
    in_range = (a < Nodes) && (b < Nodes);
    hit = in_range && has_neighbor(a, b);
    r = '0;
    r.status = aet_pkg::STAT_OK;
    case (w.func)
      aet_pkg::FUNC_CLEAR: begin
        foreach (deg[i]) begin
          deg[i] = 0;
          loaded[i] = 0;
        end
        edges = 0;
        hit = 1'b0;
      end
      aet_pkg::FUNC_LOAD: begin
        if (!in_range || !has_room(a, b, 1'b0)) begin
          r.status = aet_pkg::STAT_NO_ROOM;
        end else begin
          link_edge(a, b, w.edge_length);
          if (loaded[a] < MaxDeg) loaded[a]++;
          if (loaded[b] < MaxDeg) loaded[b]++;
        end
      end
      aet_pkg::FUNC_ADD: begin
        if (!in_range) r.status = aet_pkg::STAT_NO_ROOM;
        else if (hit) r.status = aet_pkg::STAT_PRESENT;
        else if (!has_room(a, b, 1'b1)) r.status = aet_pkg::STAT_NO_ROOM;
        else link_edge(a, b, w.edge_length);
      end
      aet_pkg::FUNC_DELETE: begin
        if (hit) begin
          detach(a, b);
          detach(b, a);
          if (edges > 0) edges--;
        end
      end
      default: ;  // queries and unused codes only report
    endcase
    r.found = hit;
    r.edge_total = edges[aet_pkg::EdgeW-1:0];
    return r;
  endfunction

  // Driver: presents the oldest pending word and retires it once the block takes it.
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_results.push_back(apply_command(in_word));
        void'(pending_words.pop_front());
      end
      // Decide what to present next; only one assignment to start per edge.
      if (start && !busy) begin
        if (pending_words.size() > 0 && (quiet_driver || $urandom_range(99) >= 11)) begin
          start <= 1'b1;
          in_word <= pending_words[0];
        end else begin
          start <= 1'b0;
        end
      end else if (!start && pending_words.size() > 0 &&
                   (quiet_driver || $urandom_range(99) >= 11)) begin
        start <= 1'b1;
        in_word <= pending_words[0];
      end
    end
    if (cycle >= CycleCap) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Monitor: every done pulse must match the oldest expected word.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %p", result);
      end else begin
        aet_pkg::out_word_t want;
        want = expected_results.pop_front();
        if (result.found !== want.found || result.status !== want.status ||
            result.edge_total !== want.edge_total) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"result mismatch: expected found=%0d status=%0d total=%0d,",
                      " got found=%0d status=%0d total=%0d"},
                     want.found, want.status, want.edge_total,
                     result.found, result.status, result.edge_total);
        end
      end
    end
  end

  function automatic aet_pkg::in_word_t make_word(logic [2:0] f, int unsigned a,
                                                  int unsigned b,
                                                  logic [aet_pkg::LenW-1:0] len);
    aet_pkg::in_word_t w;
    w.func = f;
    w.node_a = a[aet_pkg::NodeW-1:0];
    w.node_b = b[aet_pkg::NodeW-1:0];
    w.edge_length = len;
    return w;
  endfunction

  // Random nodes are mostly drawn from a small pool so that degrees climb and edges repeat.
  function automatic int unsigned pick_node();
    if ($urandom_range(9) == 0) return $urandom_range(Nodes - 1);
    return $urandom_range(11);
  endfunction

  initial begin
    aet_pkg::in_word_t w;
    int unsigned a, b, pick;
    foreach (deg[i]) begin
      deg[i] = 0;
      loaded[i] = 0;
    end
    edges = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part: every operation, field extremes and self loops.
    pending_words.push_back(make_word(aet_pkg::FUNC_QUERY, 0, 1023, '0));
    pending_words.push_back(make_word(aet_pkg::FUNC_LOAD, 0, 1023, '1));
    pending_words.push_back(make_word(aet_pkg::FUNC_LOAD, 0, 1023, 31'd5));
    pending_words.push_back(make_word(aet_pkg::FUNC_QUERY, 1023, 0, '0));
    pending_words.push_back(make_word(aet_pkg::FUNC_ADD, 0, 1023, 31'd7));
    pending_words.push_back(make_word(aet_pkg::FUNC_LOAD, 5, 5, 31'd9));
    pending_words.push_back(make_word(aet_pkg::FUNC_ADD, 6, 6, 31'd3));
    pending_words.push_back(make_word(aet_pkg::FUNC_DELETE, 5, 5, '0));
    pending_words.push_back(make_word(aet_pkg::FUNC_DELETE, 1023, 0, '0));
    pending_words.push_back(make_word(aet_pkg::FUNC_DELETE, 3, 4, '0));
    for (int i = 1; i <= 9; i++)
      pending_words.push_back(make_word(aet_pkg::FUNC_LOAD, 2, 100 + i, 31'(i)));
    pending_words.push_back(make_word(aet_pkg::FUNC_ADD, 2, 200, 31'd1));
    pending_words.push_back(make_word(aet_pkg::FUNC_ADD, 7, 8, 31'h2AAAAAAA));
    pending_words.push_back(make_word(aet_pkg::FUNC_ADD, 7, 9, 31'h55555555));
    pending_words.push_back(make_word(aet_pkg::FUNC_ADD, 7, 10, '0));
    pending_words.push_back(make_word(3'd7, 7, 8, '0));
    pending_words.push_back(make_word(aet_pkg::FUNC_CLEAR, 0, 0, '0));

    // Random part: mostly loads, adds, deletes and queries among a few busy nodes.
    for (int n = 0; n < 650; n++) begin
      pick = $urandom_range(99);
      a = pick_node();
      b = (pick % 7 == 0) ? a : pick_node();
      w = make_word(aet_pkg::FUNC_QUERY, a, b, 31'($urandom_range(32'h7FFFFFFF)));
      if (pick < 25) w.func = aet_pkg::FUNC_LOAD;
      else if (pick < 50) w.func = aet_pkg::FUNC_ADD;
      else if (pick < 72) w.func = aet_pkg::FUNC_DELETE;
      else if (pick < 97) w.func = aet_pkg::FUNC_QUERY;
      else if (pick < 99) w.func = 3'($urandom_range(5, 7));
      else w.func = aet_pkg::FUNC_CLEAR;
      // A quiet stretch without driver gaps in the middle of the run.
      if (n == 250) pending_words.push_back(make_word(aet_pkg::FUNC_QUERY, 1, 2, '0));
      pending_words.push_back(w);
    end

    wait (pending_words.size() == 300);
    quiet_driver = 1'b1;
    wait (pending_words.size() == 150);
    quiet_driver = 1'b0;
    wait (pending_words.size() == 0 && !start);
    wait (expected_results.size() == 0);
    repeat (2200) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
